// ----- sv/msob_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and the rounding helper for the modulated source-over blend.
// Depends on nothing; imported by every module of the block.
package msob_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_MODULATE = 1'b0;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] ALPHA_FULL = 32'hFF00_0000;
  localparam logic [16:0] HALF       = 17'd128;
  localparam logic [7:0]  MAXB       = 8'd255;

  // Rounded divide by 256 of a product or a sum of products: (x + 128) >> 8.
  function automatic logic [7:0] rnd_shr8(input logic [16:0] x);
    logic [16:0] t;
    t = x + HALF;
    return 8'(t >> 8);
  endfunction

endpackage

// ----- sv/modulated_src_over_pixel_blend.sv -----
`timescale 1ns / 1ps
// A pixel accepted on start passes four register stages (stage 1 to stage 4) and then
// appears on out_pixel with done high.
// Throughput: one pixel per clock cycle, sustained;
// busy stays low, as the pipeline never stalls.
// Reset (rst, synchronous, active high) clears every stage valid bit and sets
// modulate_color to all ones, which means no modulation.
// Depends on msob_pkg and msob_mix_lane.
module modulated_src_over_pixel_blend (
  input  logic                           clk,
  input  logic                           rst,
  // Pixel command channel.
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    src_pixel,
  input  logic [31:0]                    dest_pixel,
  input  logic                           row_last,
  // Result channel: one beat per pixel, marked by done for a single cycle.
  output logic                           done,
  output logic [31:0]                    out_pixel,
  output logic                           out_last,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msob_pkg::CfgAddrW-1:0]  paddr,
  input  logic [msob_pkg::CfgDataW-1:0]  pwdata,
  output logic [msob_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import msob_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register. The APB port is never wait-stated. Writes to any
  // address other than the modulate register are dropped.
  // ---------------------------------------------------------------------------
  logic [31:0] modulate_color;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulate_color <= ALL_ONES;
    end else if (cfg_wr && (paddr[2] == REG_MODULATE)) begin
      modulate_color <= pwdata;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODULATE: prdata = modulate_color;
      default:      prdata = '0;
    endcase
  end

  // The pipeline flows freely, so a new beat is taken in every cycle.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: the four modulate products x*m, one per byte including alpha.
  // The identity test on the register travels alongside as a bypass flag.
  // ---------------------------------------------------------------------------
  logic        v1;
  logic [15:0] m1_prod [4];
  logic [31:0] src1;
  logic [31:0] dest1;
  logic        last1;
  logic        bypass1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m1_prod[i] <= 16'(src_pixel[8*i +: 8]) * 16'(modulate_color[8*i +: 8]);
    end
    src1    <= src_pixel;
    dest1   <= dest_pixel;
    last1   <= row_last;
    bypass1 <= (modulate_color == ALL_ONES);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: round the products into the modulated source pixel. When the
  // register holds all ones the source passes untouched; any other value
  // scales all four bytes, even those that are 0xFF.
  // ---------------------------------------------------------------------------
  logic        v2;
  logic [31:0] mod2;
  logic [31:0] dest2;
  logic        last2;
  logic [31:0] mod_scaled;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mod_scaled[8*i +: 8] = rnd_shr8(17'(m1_prod[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mod2  <= bypass1 ? src1 : mod_scaled;
    dest2 <= dest1;
    last2 <= last1;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: the colour lanes register s*a and d*(255-a). The alpha and the
  // operands needed by the transparent and opaque cases travel beside them.
  // ---------------------------------------------------------------------------
  logic        v3;
  logic [7:0]  a3;
  logic [23:0] smod3;
  logic [31:0] dest3;
  logic        last3;
  logic [7:0]  mixed [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    msob_mix_lane u_lane (
      .clk   (clk),
      .s     (mod2[8*c +: 8]),
      .d     (dest2[8*c +: 8]),
      .a     (mod2[31:24]),
      .mixed (mixed[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    a3    <= mod2[31:24];
    smod3 <= mod2[23:0];
    dest3 <= dest2;
    last3 <= last2;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: the lanes finish the rounded sum, and the result is chosen.
  // A fully transparent source leaves the destination as it was, its alpha
  // included. An opaque source replaces the colour. Every other alpha takes
  // the mixed colour. In both latter cases the alpha is forced to 255; the
  // mix cannot exceed 254, so no clamp is needed.
  // ---------------------------------------------------------------------------
  logic [31:0] pixel_next;

  always_comb begin
    if (a3 == 8'd0) begin
      pixel_next = dest3;
    end else if (a3 == MAXB) begin
      pixel_next = ALPHA_FULL | {8'd0, smod3};
    end else begin
      pixel_next = ALPHA_FULL | {8'd0, mixed[2], mixed[1], mixed[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel <= pixel_next;
    out_last  <= last3;
  end

`ifndef SYNTHESIS
  a_bypass_passes_source: assert property (@(posedge clk) disable iff (rst)
    (v1 && bypass1) |=> (mod2 == $past(src1)))
    else $error("identity modulate altered the source pixel");

  a_transparent_keeps_dest: assert property (@(posedge clk) disable iff (rst)
    (v3 && a3 == 8'd0) |=> (done && out_pixel == $past(dest3)))
    else $error("transparent source did not return the destination");

  a_alpha_forced: assert property (@(posedge clk) disable iff (rst)
    (v3 && a3 != 8'd0) |=> (done && out_pixel[31:24] == MAXB))
    else $error("result alpha not forced to 255");

  a_opaque_takes_source: assert property (@(posedge clk) disable iff (rst)
    (v3 && a3 == MAXB) |=> (out_pixel[23:0] == $past(smod3)))
    else $error("opaque source colour not passed through");
`endif

endmodule

// ----- sv/msob_mix_lane.sv -----
`timescale 1ns / 1ps
// One colour channel of the source-over mix: registered products, then rounded sum.
// Depends on msob_pkg.
module msob_mix_lane (
  input  logic       clk,
  input  logic [7:0] s,
  input  logic [7:0] d,
  input  logic [7:0] a,
  output logic [7:0] mixed
);
  import msob_pkg::*;

  logic [15:0] ps;
  logic [15:0] pd;

  always_ff @(posedge clk) begin
    ps <= 16'(s) * 16'(a);
    pd <= 16'(d) * 16'(MAXB - a);
  end

  assign mixed = rnd_shr8(17'(ps) + 17'(pd));

endmodule
